// ===== sv/dss_pkg.sv =====
// Shared types and constants of the disk scan scheduler.
`default_nettype none

package dss_pkg;

  localparam int HEAD_W     = 16;
  localparam int DCYL_W     = 17;
  localparam int TRAVEL_W   = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [TRAVEL_W-1:0] TRAVEL_MAX = '1;
  localparam logic [DCYL_W-1:0]   DCYL_RESET = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISK_CYL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_MODE = 2'd2;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [DCYL_W-1:0] last_cyl;
    logic              cscan;
    logic              dropped;
  } job_t;

  typedef struct packed {
    logic drain;
    logic done;
  } xfer_t;

endpackage

`default_nettype wire

// ===== sv/disk_scan_cscan_scheduler.sv =====
// Top level of the SCAN / C-SCAN disk head scheduler.
// A request item is taken while busy is low, in one insertion step of the sorted chain.
// After the batch end item, busy stays high while the chain drains into RAM, and longer if
// the previous batch is still being swept. Results leave at most one per cycle and cannot
// be stalled. Sync reset loads defaults; RAM is not cleared.
`default_nettype none

module disk_scan_cscan_scheduler #(
  parameter int MAX_REQUESTS   = 32,
  parameter int CYLINDER_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [CYLINDER_WIDTH-1:0]         in_cylinder,
  input  wire logic                              in_batch_end,
  output logic                                   out_valid,
  output logic [CYLINDER_WIDTH-1:0]              out_served_cylinder,
  output logic                                   out_has_cylinder,
  output logic [dss_pkg::TRAVEL_W-1:0]           out_travel_total,
  output logic                                   out_final_result,
  output logic                                   out_overflow,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import dss_pkg::*;

  localparam int CNTW = $clog2(MAX_REQUESTS + 1);

  logic                      job_pend;
  job_t                      job;
  logic [CNTW-1:0]           job_count;
  logic [CYLINDER_WIDTH-1:0] drain_head;
  xfer_t                     xfer;

  dss_front #(.MAX(MAX_REQUESTS), .CW(CYLINDER_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cylinder  (in_cylinder),
    .in_batch_end (in_batch_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .job_pend     (job_pend),
    .job          (job),
    .job_count    (job_count),
    .drain_head   (drain_head),
    .xfer         (xfer)
  );

  dss_back #(.MAX(MAX_REQUESTS), .CW(CYLINDER_WIDTH)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_pend            (job_pend),
    .job                 (job),
    .job_count           (job_count),
    .drain_head          (drain_head),
    .xfer                (xfer),
    .out_valid           (out_valid),
    .out_served_cylinder (out_served_cylinder),
    .out_has_cylinder    (out_has_cylinder),
    .out_travel_total    (out_travel_total),
    .out_final_result    (out_final_result),
    .out_overflow        (out_overflow)
  );

endmodule

`default_nettype wire

// ===== sv/dss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/dss_front.sv =====
// Front end: configuration registers, request intake and the sorted insertion chain.
`default_nettype none

module dss_front #(
  parameter int MAX = 32,
  parameter int CW  = 16,
  localparam int CNTW = $clog2(MAX + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [CW-1:0]                     in_cylinder,
  input  wire logic                              in_batch_end,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dss_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                   job_pend,
  output dss_pkg::job_t                          job,
  output logic [CNTW-1:0]                        job_count,
  output logic [CW-1:0]                          drain_head,
  input  wire dss_pkg::xfer_t                    xfer
);

  import dss_pkg::*;

  logic [CW-1:0]     chain_r    [MAX];
  logic [CW-1:0]     chain_nxt  [MAX];
  logic [CW-1:0]     chain_prev [MAX];
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic              dropped_r, dropped_nxt;
  logic              pend_r, pend_nxt;
  job_t              job_r, job_nxt;
  logic [HEAD_W-1:0] head_cfg_r;
  logic [DCYL_W-1:0] dcyl_r;
  logic              mode_r;
  logic              accept;
  logic              full;
  logic [MAX-1:0]    gt;
  logic [MAX-1:0]    gt_prev;

  assign accept     = start && !pend_r;
  assign full       = (cnt_r == CNTW'(MAX));
  assign busy       = pend_r;
  assign cfg_ready  = 1'b1;
  assign job_pend   = pend_r;
  assign job        = job_r;
  assign job_count  = cnt_r;
  assign drain_head = chain_r[0];

  always_comb begin
    for (int i = 0; i < MAX; i++) begin
      gt[i] = (CNTW'(i) < cnt_r) && (chain_r[i] > in_cylinder);
    end
    gt_prev = MAX'({gt, 1'b0});
    chain_prev[0] = in_cylinder;
    for (int i = 1; i < MAX; i++) begin
      chain_prev[i] = chain_r[i-1];
    end
  end

  always_comb begin
    chain_nxt = chain_r;
    if (xfer.drain) begin
      for (int i = 0; i < MAX - 1; i++) begin
        chain_nxt[i] = chain_r[i+1];
      end
    end else if (accept && !full) begin
      for (int i = 0; i < MAX; i++) begin
        if ((CNTW'(i) == cnt_r) || gt[i]) begin
          chain_nxt[i] = gt_prev[i] ? chain_prev[i] : in_cylinder;
        end
      end
    end
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    dropped_nxt = dropped_r;
    pend_nxt    = pend_r;
    job_nxt     = job_r;
    if (xfer.done) begin
      cnt_nxt     = '0;
      dropped_nxt = 1'b0;
      pend_nxt    = 1'b0;
    end else if (accept) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNTW'(1);
      end
      if (in_batch_end) begin
        pend_nxt         = 1'b1;
        job_nxt.head     = head_cfg_r;
        job_nxt.last_cyl = (dcyl_r == '0) ? '0 : dcyl_r - DCYL_W'(1);
        job_nxt.cscan    = mode_r;
        job_nxt.dropped  = full || dropped_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    chain_r <= chain_nxt;
    job_r   <= job_nxt;
    if (!rst_n) begin
      cnt_r      <= '0;
      dropped_r  <= 1'b0;
      pend_r     <= 1'b0;
      head_cfg_r <= '0;
      dcyl_r     <= DCYL_RESET;
      mode_r     <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      dropped_r <= dropped_nxt;
      pend_r    <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_HEAD: head_cfg_r <= cfg_data[HEAD_W-1:0];
          REG_DISK_CYL:   dcyl_r     <= cfg_data[DCYL_W-1:0];
          REG_SWEEP_MODE: mode_r     <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  a_done_needs_pend: assert property (@(posedge clk) disable iff (!rst_n)
    xfer.done |-> pend_r)
    else $error("transfer done without a pending batch");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    xfer.done |=> (cnt_r == '0) && !dropped_r && !pend_r)
    else $error("batch state not cleared after transfer");

endmodule

`default_nettype wire

// ===== sv/dss_back.sv =====
// Back end: copies a sorted batch into RAM, sweeps it and issues the service order.
`default_nettype none

module dss_back #(
  parameter int MAX = 32,
  parameter int CW  = 16,
  localparam int CNTW = $clog2(MAX + 1),
  localparam int IW   = (MAX > 1) ? $clog2(MAX) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            job_pend,
  input  wire dss_pkg::job_t                   job,
  input  wire logic [CNTW-1:0]                 job_count,
  input  wire logic [CW-1:0]                   drain_head,
  output dss_pkg::xfer_t                       xfer,
  output logic                                 out_valid,
  output logic [CW-1:0]                        out_served_cylinder,
  output logic                                 out_has_cylinder,
  output logic [dss_pkg::TRAVEL_W-1:0]         out_travel_total,
  output logic                                 out_final_result,
  output logic                                 out_overflow
);

  import dss_pkg::*;

  localparam int DW = (CW > DCYL_W) ? CW : DCYL_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COPY, ST_HI, ST_ENDS, ST_LO, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    SK_NONE, SK_HI, SK_END, SK_LO, SK_FIN
  } slot_t;

  state_t              state_r, state_nxt;
  slot_t               slot_r, slot_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [CNTW-1:0]     n_r;
  job_t                job_r;
  logic [TRAVEL_W-1:0] travel_r, travel_nxt;
  logic [DW-1:0]       cur_r, cur_nxt;
  logic                po_v_r, po_v_nxt;
  logic [CW-1:0]       po_cyl_r, po_cyl_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CW-1:0]       out_cyl_r, out_cyl_nxt;
  logic                out_has_r, out_has_nxt;
  logic [TRAVEL_W-1:0] out_travel_r, out_travel_nxt;
  logic                out_final_r, out_final_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                is_last;
  logic                load;
  logic                we;
  logic [CW-1:0]       rdata;
  logic [CW-1:0]       head_c;
  logic [DW-1:0]       end_ext;
  logic [DW-1:0]       d_ext;
  logic [DW-1:0]       ref_val;
  logic [DW-1:0]       delta;
  logic [TRAVEL_W:0]   sum;
  logic                take;
  logic                add_en;

  dss_ram #(.WIDTH(CW), .DEPTH(MAX)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (drain_head),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign is_last = (CNTW'(idx_r) == n_r - CNTW'(1));
  assign load    = (state_r == ST_IDLE) && job_pend;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    slot_nxt   = SK_NONE;
    we         = 1'b0;
    xfer.drain = 1'b0;
    xfer.done  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (job_pend) begin
          state_nxt = ST_COPY;
          idx_nxt   = '0;
        end
      end
      ST_COPY: begin
        we         = 1'b1;
        xfer.drain = 1'b1;
        if (is_last) begin
          xfer.done = 1'b1;
          state_nxt = ST_HI;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_HI: begin
        slot_nxt = SK_HI;
        if (is_last) begin
          state_nxt = ST_ENDS;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_ENDS: begin
        slot_nxt  = SK_END;
        state_nxt = ST_LO;
        idx_nxt   = job_r.cscan ? '0 : IW'(n_r - CNTW'(1));
      end
      ST_LO: begin
        slot_nxt = SK_LO;
        if (job_r.cscan) begin
          if (is_last) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end else begin
          if (idx_r == '0) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt = idx_r - IW'(1);
          end
        end
      end
      ST_FIN: begin
        slot_nxt  = SK_FIN;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    head_c  = CW'(job_r.head);
    end_ext = DW'(job_r.last_cyl);
    d_ext   = DW'(rdata);
    take    = ((slot_r == SK_HI) && (rdata > head_c)) ||
              ((slot_r == SK_LO) && (rdata < head_c));
    add_en  = take || (slot_r == SK_END);
    ref_val = take ? d_ext : end_ext;
    delta   = (ref_val > cur_r) ? ref_val - cur_r : cur_r - ref_val;
    sum     = {1'b0, travel_r} + (TRAVEL_W + 1)'(delta);

    travel_nxt     = travel_r;
    cur_nxt        = cur_r;
    po_v_nxt       = po_v_r;
    po_cyl_nxt     = po_cyl_r;
    out_valid_nxt  = 1'b0;
    out_cyl_nxt    = po_cyl_r;
    out_has_nxt    = 1'b1;
    out_travel_nxt = '0;
    out_final_nxt  = 1'b0;
    out_ovf_nxt    = job_r.dropped;

    if (add_en) begin
      travel_nxt = sum[TRAVEL_W] ? TRAVEL_MAX : sum[TRAVEL_W-1:0];
    end
    if (take) begin
      cur_nxt       = d_ext;
      po_v_nxt      = 1'b1;
      po_cyl_nxt    = rdata;
      out_valid_nxt = po_v_r;
    end else if (slot_r == SK_END) begin
      cur_nxt = job_r.cscan ? '0 : end_ext;
    end else if (slot_r == SK_FIN) begin
      po_v_nxt       = 1'b0;
      out_valid_nxt  = 1'b1;
      out_cyl_nxt    = po_v_r ? po_cyl_r : '0;
      out_has_nxt    = po_v_r;
      out_travel_nxt = travel_r;
      out_final_nxt  = 1'b1;
    end

    if (load) begin
      travel_nxt = '0;
      cur_nxt    = DW'(CW'(job.head));
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    travel_r     <= travel_nxt;
    cur_r        <= cur_nxt;
    po_cyl_r     <= po_cyl_nxt;
    out_cyl_r    <= out_cyl_nxt;
    out_has_r    <= out_has_nxt;
    out_travel_r <= out_travel_nxt;
    out_final_r  <= out_final_nxt;
    out_ovf_r    <= out_ovf_nxt;
    if (load) begin
      job_r <= job;
      n_r   <= job_count;
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= SK_NONE;
      po_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      po_v_r      <= po_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_served_cylinder = out_cyl_r;
  assign out_has_cylinder    = out_has_r;
  assign out_travel_total    = out_travel_r;
  assign out_final_result    = out_final_r;
  assign out_overflow        = out_ovf_r;

  a_mid_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_final_r |-> out_has_r && (out_travel_r == '0))
    else $error("non-final item without cylinder or with travel");

  a_copy_has_batch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> job_pend)
    else $error("copy running without a pending batch");

  a_fin_emits_final: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_r == SK_FIN) |=> out_valid_r && out_final_r && !po_v_r)
    else $error("sweep end did not issue the final item");

endmodule

`default_nettype wire

// ===== verif/disk_scan_cscan_scheduler_checker.sv =====
// Checker for the disk scan scheduler: predicts each service order and compares the results.
`timescale 1ns / 1ps

module disk_scan_cscan_scheduler_checker #(
  parameter int MAX_REQ = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [dss_pkg::HEAD_W-1:0]     in_cylinder,
  input  logic                           in_batch_end,
  input  logic                           out_valid,
  input  logic [dss_pkg::HEAD_W-1:0]     out_served_cylinder,
  input  logic                           out_has_cylinder,
  input  logic [dss_pkg::TRAVEL_W-1:0]   out_travel_total,
  input  logic                           out_final_result,
  input  logic                           out_overflow,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);

  import dss_pkg::*;

  typedef struct packed {
    logic [HEAD_W-1:0]   served;
    logic                has_cyl;
    logic [TRAVEL_W-1:0] travel;
    logic                final_flag;
    logic                ovf;
  } service_t;

  logic [HEAD_W-1:0] head_reg;
  logic [DCYL_W-1:0] cyl_reg;
  logic              cscan_reg;

  logic [HEAD_W-1:0] batch_q[$];
  logic              batch_drop;
  service_t          service_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    head_reg   = '0;
    cyl_reg    = DCYL_RESET;
    cscan_reg  = 1'b0;
    batch_drop = 1'b0;
  end

  function automatic longint cyl_distance(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void post_served(logic [HEAD_W-1:0] cyl);
    service_t r;
    r.served     = cyl;
    r.has_cyl    = 1'b1;
    r.travel     = '0;
    r.final_flag = 1'b0;
    r.ovf        = batch_drop;
    service_q    = {service_q, r};
  endfunction

  // The batch store is kept in ascending order, so both sweeps walk it directly.
  function automatic void plan_batch();
    longint   pos;
    longint   trip;
    longint   last_cyl;
    int       first;
    int       idx;
    service_t r;
    first    = service_q.size();
    trip     = 0;
    pos      = head_reg;
    last_cyl = (cyl_reg == '0) ? 0 : longint'(cyl_reg) - 1;
    for (int i = 0; i < batch_q.size(); i++) begin
      if (batch_q[i] > head_reg) begin
        trip += cyl_distance(batch_q[i], pos);
        pos = batch_q[i];
        post_served(batch_q[i]);
      end
    end
    trip += cyl_distance(last_cyl, pos);
    if (cscan_reg) begin
      pos = 0;
      for (int i = 0; i < batch_q.size(); i++) begin
        if (batch_q[i] < head_reg) begin
          trip += cyl_distance(batch_q[i], pos);
          pos = batch_q[i];
          post_served(batch_q[i]);
        end
      end
    end else begin
      pos = last_cyl;
      for (int i = batch_q.size() - 1; i >= 0; i--) begin
        if (batch_q[i] < head_reg) begin
          trip += cyl_distance(batch_q[i], pos);
          pos = batch_q[i];
          post_served(batch_q[i]);
        end
      end
    end
    if (service_q.size() == first) begin
      r.served     = '0;
      r.has_cyl    = 1'b0;
      r.travel     = '0;
      r.final_flag = 1'b0;
      r.ovf        = batch_drop;
      service_q    = {service_q, r};
    end
    idx = service_q.size() - 1;
    service_q[idx].travel     = (trip > longint'(TRAVEL_MAX)) ? TRAVEL_MAX : trip[TRAVEL_W-1:0];
    service_q[idx].final_flag = 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    int       k;
    service_t want;
    service_t got;
    if (!rst_n) begin
      head_reg   = '0;
      cyl_reg    = DCYL_RESET;
      cscan_reg  = 1'b0;
      batch_drop = 1'b0;
      batch_q.delete();
      service_q.delete();
    end else begin
      if (out_valid) begin
        got.served     = out_served_cylinder;
        got.has_cyl    = out_has_cylinder;
        got.travel     = out_travel_total;
        got.final_flag = out_final_result;
        got.ovf        = out_overflow;
        if (service_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("[%0t] unexpected result item: cyl %0d has %0b travel %0d final %0b ovf %0b",
                     $time, got.served, got.has_cyl, got.travel, got.final_flag, got.ovf);
          end
        end else begin
          want = service_q.pop_front();
          checked++;
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] mismatch: expected cyl %0d has %0b travel %0d final %0b ovf %0b",
                       $time, want.served, want.has_cyl, want.travel, want.final_flag, want.ovf);
              $display("[%0t]           got      cyl %0d has %0b travel %0d final %0b ovf %0b",
                       $time, got.served, got.has_cyl, got.travel, got.final_flag, got.ovf);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_HEAD: head_reg  = cfg_data[HEAD_W-1:0];
          REG_DISK_CYL:   cyl_reg   = cfg_data[DCYL_W-1:0];
          REG_SWEEP_MODE: cscan_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (batch_q.size() < MAX_REQ) begin
          k = 0;
          while (k < batch_q.size() && batch_q[k] <= in_cylinder) k++;
          batch_q.insert(k, in_cylinder);
        end else begin
          batch_drop = 1'b1;
        end
        if (in_batch_end) begin
          plan_batch();
          batch_q.delete();
          batch_drop = 1'b0;
        end
      end
    end
    pending = service_q.size();
  end

endmodule

// ===== verif/disk_scan_cscan_scheduler_tb.sv =====
// Testbench top for the disk scan scheduler: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module disk_scan_cscan_scheduler_tb;
  import dss_pkg::*;

  localparam int MAX_REQ   = 32;
  localparam int SETTLE    = 3 * MAX_REQ + 10;
  localparam int LIMIT     = 200000;
  localparam int N_ITEMS   = 380;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [HEAD_W-1:0]     in_cylinder;
  logic                  in_batch_end;
  logic                  out_valid;
  logic [HEAD_W-1:0]     out_served_cylinder;
  logic                  out_has_cylinder;
  logic [TRAVEL_W-1:0]   out_travel_total;
  logic                  out_final_result;
  logic                  out_overflow;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int cycles;
  int n_items;
  int n_batches;
  int n_settings;
  logic quiet;

  logic [HEAD_W-1:0] cur_head;
  logic [DCYL_W-1:0] cur_cyl;

  disk_scan_cscan_scheduler #(
    .MAX_REQUESTS(MAX_REQ),
    .CYLINDER_WIDTH(HEAD_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cylinder(in_cylinder),
    .in_batch_end(in_batch_end),
    .out_valid(out_valid),
    .out_served_cylinder(out_served_cylinder),
    .out_has_cylinder(out_has_cylinder),
    .out_travel_total(out_travel_total),
    .out_final_result(out_final_result),
    .out_overflow(out_overflow),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  disk_scan_cscan_scheduler_checker #(
    .MAX_REQ(MAX_REQ)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cylinder(in_cylinder),
    .in_batch_end(in_batch_end),
    .out_valid(out_valid),
    .out_served_cylinder(out_served_cylinder),
    .out_has_cylinder(out_has_cylinder),
    .out_travel_total(out_travel_total),
    .out_final_result(out_final_result),
    .out_overflow(out_overflow),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending),
    .checked(checked)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Run stopped after %0d cycles with %0d result items outstanding.", cycles, pending);
      $display("FAIL disk_scan_cscan_scheduler");
      $finish;
    end
  end

  task automatic send_request(input logic [HEAD_W-1:0] cyl, input logic last);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 10) gap = 1;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_cylinder  <= cyl;
    in_batch_end <= last;
    do @(posedge clk); while (busy);
    @(negedge clk);
    n_items++;
  endtask

  // Waits until every predicted result item has come out, then lets the block go quiet.
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [HEAD_W-1:0] h, input logic [DCYL_W-1:0] c,
                               input logic m);
    write_reg(REG_START_HEAD, {1'($urandom), h});
    write_reg(REG_DISK_CYL, c);
    write_reg(REG_SWEEP_MODE, {16'($urandom), m});
    cfg_valid  <= 1'b0;
    cur_head   = h;
    cur_cyl    = c;
    n_settings++;
  endtask

  task automatic random_setting();
    logic [HEAD_W-1:0] h;
    logic [DCYL_W-1:0] c;
    case ($urandom_range(0, 4))
      0:       h = '0;
      1:       h = 16'hFFFF;
      2:       h = 16'h8000;
      default: h = 16'($urandom);
    endcase
    case ($urandom_range(0, 6))
      0:       c = '0;
      1:       c = 17'd1;
      2:       c = 17'h10000;
      3:       c = 17'h0FFFF;
      4:       c = 17'($urandom_range(2, 300));
      default: c = 17'($urandom_range(1, 65536));
    endcase
    apply_setting(h, c, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [HEAD_W-1:0] pick_cylinder();
    case ($urandom_range(0, 9))
      0:       return cur_head;
      1:       return '0;
      2:       return 16'hFFFF;
      3:       return (cur_cyl == '0) ? '0 : 16'(cur_cyl - 1);
      4:       return cur_head + 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_batch(input int count);
    for (int i = 0; i < count; i++) send_request(pick_cylinder(), i == count - 1);
    n_batches++;
  endtask

  initial begin
    int size;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_cylinder  <= '0;
    in_batch_end <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    quiet        = 1'b0;
    n_items      = 0;
    n_batches    = 0;
    n_settings   = 1;
    cur_head     = '0;
    cur_cyl      = DCYL_RESET;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: a batch that only asks for the head, then a plain SCAN batch.
    send_request(16'h0000, 1'b1);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0001, 1'b0);
    send_request(16'hAAAA, 1'b0);
    send_request(16'h5555, 1'b1);
    n_batches += 2;
    settle();

    write_reg(REG_SPARE, 17'h1FFFF);
    apply_setting(16'h8000, 17'h10000, 1'b1);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b0);
    send_request(16'h8000, 1'b0);
    send_request(16'h7FFF, 1'b0);
    send_request(16'h8001, 1'b1);
    n_batches++;
    settle();

    apply_setting(16'h8000, 17'h10000, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b0);
    send_request(16'h8000, 1'b0);
    send_request(16'h7FFF, 1'b0);
    send_request(16'h8001, 1'b1);
    n_batches++;
    settle();

    // Zero cylinders with the head far past the last cylinder.
    apply_setting(16'hFFFF, 17'd0, 1'b1);
    send_request(16'h1234, 1'b0);
    send_request(16'hFFFF, 1'b1);
    n_batches++;
    settle();

    apply_setting(16'd10, 17'd1, 1'b0);
    send_request(16'd5, 1'b0);
    send_request(16'd20, 1'b0);
    send_request(16'd10, 1'b1);
    n_batches++;
    settle();

    while (n_items < N_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        random_setting();
      end
      quiet = (n_items >= 150 && n_items < 260);
      case ($urandom_range(0, 9))
        0:       size = $urandom_range(11, MAX_REQ);
        1:       size = $urandom_range(MAX_REQ + 1, MAX_REQ + 8);
        default: size = $urandom_range(1, 10);
      endcase
      send_batch(size);
    end
    settle();

    $display("Sent %0d request items in %0d batches under %0d register settings.",
             n_items, n_batches, n_settings);
    $display("Checked %0d result items, %0d failures.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS disk_scan_cscan_scheduler");
    end else begin
      $display("FAIL disk_scan_cscan_scheduler");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dss_pkg.sv
sv/dss_ram.sv
sv/dss_front.sv
sv/dss_back.sv
sv/disk_scan_cscan_scheduler.sv
verif/disk_scan_cscan_scheduler_checker.sv
verif/disk_scan_cscan_scheduler_tb.sv
